FILE: design/mptk_pkg.sv
// ----------------------------------------------------------------------------
// mptk_pkg
// Shared types, codes and constants of the monophonic pitch-to-MIDI tracker.
// ----------------------------------------------------------------------------
package mptk_pkg;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        EV_NOTE_ON  = 2'd0,
        EV_NOTE_OFF = 2'd1,
        EV_BEND     = 2'd2
    } ev_kind_t;

    typedef enum logic [2:0] {
        CFG_SENSITIVITY = 3'd0,
        CFG_BEND_ENABLE = 3'd1,
        CFG_BEND_RANGE  = 3'd2,
        CFG_HYSTERESIS  = 3'd3,
        CFG_STABLE_REQ  = 3'd4,
        CFG_RELEASE     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic        req_type;
        logic        gate_open;
        logic        estimate_valid;
        logic [22:0] freq_q8;
        logic [15:0] envelope_q15;
    } sample_t;

    typedef struct packed {
        ev_kind_t    event_kind;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [13:0] bend_value;
        logic        detector_reset;
        logic        last_event;
    } midi_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FL_OFF,
        ST_FL_BEND,
        ST_REL_OFF,
        ST_LF_GO,
        ST_LF_WAIT,
        ST_DECIDE,
        ST_LE_GO,
        ST_LE_WAIT,
        ST_ND_GO,
        ST_ND_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_VMUL,
        ST_BD_GO,
        ST_BD_WAIT,
        ST_B_CHK,
        ST_T_OFF,
        ST_T_BEND,
        ST_T_ON,
        ST_S_BEND
    } ctrl_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQR
    } lg_state_t;

    typedef struct packed {
        logic     load;
        logic     log_start;
        logic     log_env;
        logic     db_cap;
        logic     div_start;
        logic     div_bend;
        logic     sqrt_start;
        logic     pos_cap;
        logic     vmul;
        logic     cand_upd;
        logic     cand_clr;
        logic     emit;
        ev_kind_t emit_kind;
        logic     emit_last;
        logic     emit_dr;
        logic     emit_ctr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic flush;
        logic gate;
        logic est_ok;
        logic rel_hit;
        logic active;
        logic log_done;
        logic div_done;
        logic sqrt_done;
        logic note_ok;
        logic is_new;
        logic trigger;
        logic bend_en;
        logic bend_big;
        logic lb_off_ctr;
        logic env_zero;
        logic out_free;
    } dp_stat_t;

    localparam logic [13:0] BEND_CENTRE = 14'd8192;
    localparam logic [13:0] BEND_MAX    = 14'd16383;
    localparam logic [13:0] BEND_MIN    = 14'd1;
    localparam int          BEND_STEP   = 20;

    localparam logic signed [25:0] NOTE69_Q16   = 26'sd4521984;
    localparam logic signed [21:0] LOG2_440_Q16 = 22'sd1099783;
    localparam logic signed [21:0] LOG2_ENV_REF = 22'sd983040;
    localparam logic signed [41:0] DB_PER_OCT   = 42'sd394566;
    localparam logic signed [26:0] DB_FLOOR     = 27'sd3276800;
    localparam logic [19:0]        DB_SPAN      = 20'd44;
    localparam logic [16:0]        NORM_MAX     = 17'd65536;
    localparam logic [6:0]         VEL_MAX      = 7'd127;

    localparam logic [9:0]  RST_SENSITIVITY = 10'd256;
    localparam logic        RST_BEND_ENABLE = 1'b1;
    localparam logic [3:0]  RST_BEND_RANGE  = 4'd2;
    localparam logic [11:0] RST_HYSTERESIS  = 12'd128;
    localparam logic [7:0]  RST_STABLE_REQ  = 8'd2;
    localparam logic [15:0] RST_RELEASE     = 16'd2400;

endpackage

FILE: design/mptk_log2.sv
// ----------------------------------------------------------------------------
// mptk_log2
// Iterative log2 in Q16: leading-one search one bit a cycle, then sixteen
// squarings of the Q30 mantissa, one fraction bit a cycle.
// ----------------------------------------------------------------------------
module mptk_log2
    import mptk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [22:0] x,
    output logic        done,
    output logic [20:0] result
);

    lg_state_t   state_reg, state_next;
    logic [30:0] y_reg;
    logic [4:0]  exp_reg;
    logic [15:0] frac_reg;
    logic [3:0]  cnt_reg;
    logic        done_reg;

    logic        do_load;
    logic        do_shift;
    logic        do_square;
    logic [61:0] sq;
    logic [31:0] sq_hi;

    assign sq    = 62'(y_reg) * 62'(y_reg);
    assign sq_hi = sq[61:30];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                if (y_reg[30] || exp_reg == 5'd0)
                begin
                    state_next = LG_SQR;
                end
            end
            LG_SQR:
            begin
                if (cnt_reg == 4'd15)
                begin
                    state_next = LG_IDLE;
                end
            end
            default:
            begin
                state_next = LG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        do_load   = 1'b0;
        do_shift  = 1'b0;
        do_square = 1'b0;
        case (state_reg)
            LG_IDLE: do_load   = start;
            LG_NORM: do_shift  = !y_reg[30] && exp_reg != 5'd0;
            LG_SQR:  do_square = 1'b1;
            default: do_load   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= do_square && cnt_reg == 4'd15;
            if (do_load)
            begin
                cnt_reg <= 4'd0;
            end
            else if (do_square)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            y_reg    <= 31'(x);
            exp_reg  <= 5'd30;
            frac_reg <= 16'd0;
        end
        else if (do_shift)
        begin
            y_reg   <= {y_reg[29:0], 1'b0};
            exp_reg <= exp_reg - 5'd1;
        end
        else if (do_square)
        begin
            frac_reg <= {frac_reg[14:0], sq_hi[31]};
            y_reg    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
        end
    end

    assign done   = done_reg;
    assign result = {exp_reg, frac_reg};

endmodule

FILE: design/mptk_div.sv
// ----------------------------------------------------------------------------
// mptk_div
// Restoring divider, one quotient bit a cycle, 17 quotient bits.
// Quotient is valid while num < den * 2^17 and holds until the next start.
// ----------------------------------------------------------------------------
module mptk_div
    import mptk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] num,
    input  logic [19:0] den,
    output logic        done,
    output logic [16:0] quo
);

    logic [33:0] rem_reg;
    logic [35:0] dsh_reg;
    logic [16:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        ge;

    assign ge = {2'b00, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, 16'd0};
            quo_reg <= 17'd0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[33:0];
            end
            quo_reg <= {quo_reg[15:0], ge};
            dsh_reg <= {1'b0, dsh_reg[35:1]};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/mptk_ctrl.sv
// ----------------------------------------------------------------------------
// mptk_ctrl
// Sequencer of the tracker: steps one request through log2, divide and
// square-root phases and emits up to three MIDI events.
// ----------------------------------------------------------------------------
module mptk_ctrl
    import mptk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    if (stat.flush)
                    begin
                        state_next = stat.active ? ST_FL_OFF : ST_FL_BEND;
                    end
                    else if (stat.gate)
                    begin
                        state_next = stat.est_ok ? ST_LF_GO : ST_IDLE;
                    end
                    else if (stat.rel_hit)
                    begin
                        state_next = ST_REL_OFF;
                    end
                end
            end
            ST_FL_OFF:  if (stat.out_free) state_next = ST_FL_BEND;
            ST_FL_BEND: if (stat.out_free) state_next = ST_IDLE;
            ST_REL_OFF: if (stat.out_free) state_next = ST_IDLE;
            ST_LF_GO:   state_next = ST_LF_WAIT;
            ST_LF_WAIT: if (stat.log_done) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!stat.note_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.is_new)
                begin
                    state_next = stat.trigger ? ST_LE_GO : ST_IDLE;
                end
                else if (stat.bend_en)
                begin
                    state_next = ST_BD_GO;
                end
                else
                begin
                    state_next = stat.lb_off_ctr ? ST_S_BEND : ST_IDLE;
                end
            end
            ST_LE_GO:   state_next = stat.env_zero ? ST_SQ_GO : ST_LE_WAIT;
            ST_LE_WAIT: if (stat.log_done) state_next = ST_ND_GO;
            ST_ND_GO:   state_next = ST_ND_WAIT;
            ST_ND_WAIT: if (stat.div_done) state_next = ST_SQ_GO;
            ST_SQ_GO:   state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: if (stat.sqrt_done) state_next = ST_VMUL;
            ST_VMUL:
            begin
                if (stat.bend_en)
                begin
                    state_next = ST_BD_GO;
                end
                else
                begin
                    state_next = stat.active ? ST_T_OFF : ST_T_ON;
                end
            end
            ST_BD_GO:   state_next = ST_BD_WAIT;
            ST_BD_WAIT: if (stat.div_done) state_next = ST_B_CHK;
            ST_B_CHK:
            begin
                if (stat.is_new)
                begin
                    state_next = stat.active ? ST_T_OFF : ST_T_BEND;
                end
                else
                begin
                    state_next = stat.bend_big ? ST_S_BEND : ST_IDLE;
                end
            end
            ST_T_OFF:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.bend_en ? ST_T_BEND : ST_T_ON;
                end
            end
            ST_T_BEND:  if (stat.out_free) state_next = ST_T_ON;
            ST_T_ON:    if (stat.out_free) state_next = ST_IDLE;
            ST_S_BEND:  if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = EV_BEND;
        sample_stall  = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:    cmd.load = sample_valid;
            ST_FL_OFF:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_NOTE_OFF;
            end
            ST_FL_BEND:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_BEND;
                cmd.emit_ctr  = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.cand_clr  = stat.out_free;
            end
            ST_REL_OFF:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_NOTE_OFF;
                cmd.emit_dr   = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.cand_clr  = stat.out_free;
            end
            ST_LF_GO:   cmd.log_start = 1'b1;
            ST_LF_WAIT: cmd.pos_cap = stat.log_done;
            ST_DECIDE:
            begin
                cmd.cand_upd = stat.note_ok && stat.is_new;
                cmd.cand_clr = stat.note_ok && !stat.is_new;
            end
            ST_LE_GO:
            begin
                cmd.log_start = !stat.env_zero;
                cmd.log_env   = 1'b1;
            end
            ST_LE_WAIT: cmd.db_cap = stat.log_done;
            ST_ND_GO:   cmd.div_start = 1'b1;
            ST_SQ_GO:   cmd.sqrt_start = 1'b1;
            ST_VMUL:    cmd.vmul = 1'b1;
            ST_BD_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_bend  = 1'b1;
            end
            ST_T_OFF:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_NOTE_OFF;
            end
            ST_T_BEND:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_BEND;
            end
            ST_T_ON:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_NOTE_ON;
                cmd.emit_last = 1'b1;
                cmd.cand_clr  = stat.out_free;
            end
            ST_S_BEND:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EV_BEND;
                cmd.emit_ctr  = !stat.bend_en;
                cmd.emit_last = 1'b1;
            end
            default:    cmd.load = 1'b0;
        endcase
    end

endmodule

FILE: design/mptk_dp.sv
// ----------------------------------------------------------------------------
// mptk_dp
// Datapath: configuration and tracker state, note position and hysteresis,
// velocity chain (log2, dB, divide, square root, gain), bend divide and the
// event output register.
// ----------------------------------------------------------------------------
module mptk_dp
    import mptk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sample_t     sample,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    output logic        midi_valid,
    input  logic        midi_stall,
    output midi_t       midi
);

    // configuration
    logic [9:0]  sens_reg;
    logic        bend_en_reg;
    logic [3:0]  brange_reg;
    logic [11:0] hyst_reg;
    logic [7:0]  sreq_reg;
    logic [15:0] rel_reg;

    // tracker state
    logic [6:0]  cur_reg;
    logic        active_reg;
    logic [6:0]  cand_reg;
    logic        cv_reg;
    logic [7:0]  sc_reg;
    logic [13:0] lb_reg;
    logic [15:0] goc_reg;

    // request and work registers
    logic [22:0]        freq_reg;
    logic [15:0]        env_reg;
    logic signed [25:0] pos_reg;
    logic signed [10:0] note_reg;
    logic signed [26:0] t_reg;
    logic [26:0]        p_reg;
    logic [33:0]        sv_reg;
    logic [33:0]        sr_reg;
    logic [33:0]        sb_reg;
    logic               sq_busy_reg;
    logic               sq_done_reg;
    logic               mv_reg;
    midi_t              md_reg;

    // units
    logic [20:0] log_res;
    logic        log_done;
    logic [22:0] log_x;
    logic [33:0] div_num;
    logic [19:0] div_den;
    logic        div_done;
    logic [16:0] div_q;

    assign log_x = cmd.log_env ? 23'(env_reg) : freq_reg;

    mptk_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    mptk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // release counter
    logic [15:0] goc_inc;
    logic        rel_hit;
    assign goc_inc = (goc_reg == 16'hFFFF) ? goc_reg : goc_reg + 16'd1;
    assign rel_hit = active_reg && !sample.gate_open && goc_inc > rel_reg;

    // note position: 69 + 12*(log2(f) - log2(440)) in Q16
    logic signed [21:0] lf_d;
    logic signed [25:0] pos_c;
    logic [25:0]        pos_abs;
    logic [25:0]        rnd_sum;
    logic [9:0]         rnd;
    logic signed [10:0] note_r;
    logic signed [25:0] dev_h;
    logic [25:0]        abs_h;
    logic [25:0]        lim_h;
    logic               keep;
    logic signed [10:0] note_c;

    assign lf_d    = $signed({1'b0, log_res}) - LOG2_440_Q16;
    assign pos_c   = NOTE69_Q16 + 26'(lf_d) * 26'sd12;
    assign pos_abs = pos_c[25] ? 26'(-pos_c) : 26'(pos_c);
    assign rnd_sum = pos_abs + 26'd32768;
    assign rnd     = rnd_sum[25:16];
    assign note_r  = pos_c[25] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    assign dev_h   = pos_c - $signed({3'b000, cur_reg, 16'd0});
    assign abs_h   = dev_h[25] ? 26'(-dev_h) : 26'(dev_h);
    assign lim_h   = {6'd0, hyst_reg, 8'd0};
    assign keep    = active_reg && abs_h < lim_h;
    assign note_c  = keep ? $signed({4'd0, cur_reg}) : note_r;

    // candidate tracking
    logic [6:0] note7;
    logic       note_ok;
    logic       is_new;
    logic [7:0] sc_inc;
    logic [7:0] sc_c;
    logic       cand_match;

    assign note7      = note_reg[6:0];
    assign note_ok    = (note_reg[10:7] == 4'd0);
    assign is_new     = !active_reg || note7 != cur_reg;
    assign sc_inc     = (sc_reg == 8'hFF) ? sc_reg : sc_reg + 8'd1;
    assign cand_match = cv_reg && cand_reg == note7;
    assign sc_c       = cand_match ? sc_inc : 8'd1;

    // bend: floor((8192*lim + 8191*dev) / lim), saturated outside the range
    logic [3:0]         rng;
    logic [19:0]        lim_b;
    logic signed [27:0] lim_s;
    logic signed [26:0] note_sh;
    logic signed [27:0] dev_b;
    logic               sat_hi;
    logic               sat_lo;
    logic signed [35:0] num_bs;
    logic [13:0]        nb;
    logic signed [14:0] bdiff;
    logic               bend_big;

    assign rng     = (brange_reg == 4'd0) ? 4'd1 : brange_reg;
    assign lim_b   = {rng, 16'd0};
    assign lim_s   = $signed({8'd0, lim_b});
    assign note_sh = $signed({note_reg, 16'd0});
    assign dev_b   = 28'(pos_reg) - 28'(note_sh);
    assign sat_hi  = dev_b >= lim_s;
    assign sat_lo  = dev_b <= -lim_s;
    assign num_bs  = $signed({3'b000, rng, 29'd0}) + 36'(dev_b) * 36'sd8191;
    assign nb      = sat_hi ? BEND_MAX : (sat_lo ? BEND_MIN : div_q[13:0]);
    assign bdiff   = $signed({1'b0, nb}) - $signed({1'b0, lb_reg});
    assign bend_big = bdiff > 15'sd20 || bdiff < -15'sd20;

    // velocity: dB of the envelope, truncated toward zero
    logic signed [21:0] ld_e;
    logic signed [41:0] prod;
    logic signed [41:0] prod_adj;
    logic signed [25:0] db;
    logic signed [26:0] t_c;
    logic               t_pos;
    logic [33:0]        num_v;
    logic [16:0]        norm;
    logic               env_zero;

    assign ld_e     = $signed({1'b0, log_res}) - LOG2_ENV_REF;
    assign prod     = 42'(ld_e) * DB_PER_OCT;
    assign prod_adj = prod + (prod[41] ? 42'sd65535 : 42'sd0);
    assign db       = 26'(prod_adj >>> 16);
    assign t_c      = 27'(db) + DB_FLOOR;
    assign t_pos    = !t_reg[26] && t_reg != 27'sd0;
    assign num_v    = t_pos ? 34'(t_reg[25:0]) : 34'd0;
    assign env_zero = (env_reg == 16'd0);
    assign norm     = (env_zero || !t_pos) ? 17'd0 :
                      ((div_q > NORM_MAX) ? NORM_MAX : div_q);

    assign div_num = cmd.div_bend ? num_bs[33:0] : num_v;
    assign div_den = cmd.div_bend ? lim_b : DB_SPAN;

    // square root, digit by digit
    logic [33:0] sq_sum;
    logic        sq_ge;
    assign sq_sum = sr_reg + sb_reg;
    assign sq_ge  = sv_reg >= sq_sum;

    // velocity gain and clamp
    logic [33:0] pm;
    logic [9:0]  vr;
    logic [6:0]  vel;
    assign pm  = {p_reg, 7'd0} - 34'(p_reg);
    assign vr  = pm[33:24];
    assign vel = (vr == 10'd0) ? 7'd1 : ((vr > 10'(VEL_MAX)) ? VEL_MAX : vr[6:0]);

    // event payload
    midi_t ev;
    always_comb
    begin
        ev.event_kind     = cmd.emit_kind;
        ev.note_number    = 7'd0;
        ev.velocity       = 7'd0;
        ev.bend_value     = BEND_CENTRE;
        ev.detector_reset = cmd.emit_dr;
        ev.last_event     = cmd.emit_last;
        case (cmd.emit_kind)
            EV_NOTE_OFF: ev.note_number = cur_reg;
            EV_NOTE_ON:
            begin
                ev.note_number = note7;
                ev.velocity    = vel;
            end
            EV_BEND:     ev.bend_value = cmd.emit_ctr ? BEND_CENTRE : nb;
            default:     ev.bend_value = BEND_CENTRE;
        endcase
    end

    logic out_free;
    assign out_free = !mv_reg || !midi_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg    <= RST_SENSITIVITY;
            bend_en_reg <= RST_BEND_ENABLE;
            brange_reg  <= RST_BEND_RANGE;
            hyst_reg    <= RST_HYSTERESIS;
            sreq_reg    <= RST_STABLE_REQ;
            rel_reg     <= RST_RELEASE;
            cur_reg     <= 7'd0;
            active_reg  <= 1'b0;
            cand_reg    <= 7'd0;
            cv_reg      <= 1'b0;
            sc_reg      <= 8'd0;
            lb_reg      <= BEND_CENTRE;
            goc_reg     <= 16'd0;
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    CFG_SENSITIVITY: sens_reg    <= cfg_wdata[9:0];
                    CFG_BEND_ENABLE: bend_en_reg <= cfg_wdata[0];
                    CFG_BEND_RANGE:  brange_reg  <= cfg_wdata[3:0];
                    CFG_HYSTERESIS:  hyst_reg    <= cfg_wdata[11:0];
                    CFG_STABLE_REQ:  sreq_reg    <= cfg_wdata[7:0];
                    CFG_RELEASE:     rel_reg     <= cfg_wdata;
                    default:         rel_reg     <= rel_reg;
                endcase
            end

            // gate counter moves only on sample requests
            if (cmd.load && sample.req_type == REQ_SAMPLE)
            begin
                if (sample.gate_open)
                begin
                    goc_reg <= 16'd0;
                end
                else if (active_reg)
                begin
                    goc_reg <= goc_inc;
                end
            end

            if (cmd.cand_upd)
            begin
                cand_reg <= note7;
                cv_reg   <= 1'b1;
                sc_reg   <= sc_c;
            end
            else if (cmd.cand_clr)
            begin
                cand_reg <= 7'd0;
                cv_reg   <= 1'b0;
                sc_reg   <= 8'd0;
            end

            if (cmd.emit)
            begin
                case (cmd.emit_kind)
                    EV_NOTE_OFF:
                    begin
                        active_reg <= 1'b0;
                        cur_reg    <= 7'd0;
                        lb_reg     <= BEND_CENTRE;
                    end
                    EV_NOTE_ON:
                    begin
                        active_reg <= 1'b1;
                        cur_reg    <= note7;
                    end
                    EV_BEND:     lb_reg <= ev.bend_value;
                    default:     lb_reg <= lb_reg;
                endcase
            end

            // square-root sequencing
            sq_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sb_reg[0])
            begin
                sq_busy_reg <= 1'b0;
                sq_done_reg <= 1'b1;
            end

            // hold the event until taken
            if (cmd.emit)
            begin
                mv_reg <= 1'b1;
            end
            else if (mv_reg && !midi_stall)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg <= sample.freq_q8;
            env_reg  <= sample.envelope_q15;
        end
        if (cmd.pos_cap)
        begin
            pos_reg  <= pos_c;
            note_reg <= note_c;
        end
        if (cmd.db_cap)
        begin
            t_reg <= t_c;
        end
        if (cmd.sqrt_start)
        begin
            sv_reg <= {1'b0, norm, 16'd0};
            sr_reg <= 34'd0;
            sb_reg <= 34'h1_0000_0000;
        end
        else if (sq_busy_reg)
        begin
            if (sq_ge)
            begin
                sv_reg <= sv_reg - sq_sum;
                sr_reg <= {1'b0, sr_reg[33:1]} + sb_reg;
            end
            else
            begin
                sr_reg <= {1'b0, sr_reg[33:1]};
            end
            sb_reg <= {2'b00, sb_reg[33:2]};
        end
        if (cmd.vmul)
        begin
            p_reg <= 27'(sr_reg[16:0]) * 27'(sens_reg);
        end
        if (cmd.emit)
        begin
            md_reg <= ev;
        end
    end

    always_comb
    begin
        stat.flush      = (sample.req_type == REQ_FLUSH);
        stat.gate       = sample.gate_open;
        stat.est_ok     = sample.estimate_valid && sample.freq_q8 != 23'd0;
        stat.rel_hit    = rel_hit;
        stat.active     = active_reg;
        stat.log_done   = log_done;
        stat.div_done   = div_done;
        stat.sqrt_done  = sq_done_reg;
        stat.note_ok    = note_ok;
        stat.is_new     = is_new;
        stat.trigger    = sc_c >= sreq_reg;
        stat.bend_en    = bend_en_reg;
        stat.bend_big   = bend_big;
        stat.lb_off_ctr = lb_reg != BEND_CENTRE;
        stat.env_zero   = env_zero;
        stat.out_free   = out_free;
    end

    assign midi_valid = mv_reg;
    assign midi       = md_reg;

endmodule

FILE: design/mono_pitch_to_midi_tracker_core.sv
// ----------------------------------------------------------------------------
// mono_pitch_to_midi_tracker_core
// Monophonic pitch tracker: turns gated pitch estimates into MIDI note-on,
// note-off and pitch-bend events.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  sample   | in        | sample_valid/sample_stall | sample_t (one request)
//  midi     | out       | midi_valid/midi_stall     | midi_t (one event)
//  cfg      | in        | cfg_wen                   | cfg_addr, cfg_wdata
//
// One request at a time. Flush and release emit one event per cycle while the
// output is free. An estimate costs a log2 (bit-serial leading-one search
// plus 16 squarings) and, with bend enabled, a bend divide; a new note adds
// the envelope log2, a divide by 44 and a square root, the first two skipped
// for a zero envelope. Reset is asynchronous and clears control, configuration
// and tracker state, not the work registers. An event held by midi_stall stalls
// the sequencer at its next event; sample is taken only when idle.
// ----------------------------------------------------------------------------
module mono_pitch_to_midi_tracker_core
    import mptk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        midi_valid,
    input  logic        midi_stall,
    output midi_t       midi,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mptk_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    mptk_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .midi_valid (midi_valid),
        .midi_stall (midi_stall),
        .midi       (midi)
    );

    a_on_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        midi_valid && midi.event_kind == EV_NOTE_ON |-> midi.velocity != 7'd0)
        else $error("note-on with zero velocity");

    a_release_off: assert property (@(posedge clk) disable iff (!rst_n)
        midi_valid && midi.detector_reset
        |-> midi.event_kind == EV_NOTE_OFF && midi.last_event)
        else $error("detector reset outside a final note-off");

    a_bend_fields: assert property (@(posedge clk) disable iff (!rst_n)
        midi_valid && midi.event_kind == EV_BEND
        |-> midi.note_number == 7'd0 && midi.velocity == 7'd0)
        else $error("pitch bend carries note fields");

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample.req_type == REQ_FLUSH |=> sample_stall)
        else $error("flush request did not start event output");

endmodule

FILE: verif/mptk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mptk_checker
// Watches the sample and midi channels, predicts each request's MIDI events
// from a local model of the tracker and compares them field by field.
// ----------------------------------------------------------------------------
module mptk_checker
    import mptk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_stall,
    input  sample_t     sample,
    input  logic        midi_valid,
    input  logic        midi_stall,
    input  midi_t       midi,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    logic [9:0]  sens;
    logic        bend_en;
    logic [3:0]  brange;
    logic [11:0] hyst;
    logic [7:0]  stable_req;
    logic [15:0] rel_samples;

    logic [6:0]  cur_note;
    logic        active;
    logic [6:0]  cand_note;
    logic        cand_ok;
    logic [7:0]  stable_cnt;
    logic [13:0] last_bend;
    logic [15:0] gate_off_cnt;

    midi_t       event_q[$];
    midi_t       step_ev[$];

    assign pending = event_q.size();

    function automatic longint log2_fix(longint unsigned x);
        longint unsigned y;
        longint n;
        longint frac;
        n = 0;
        frac = 0;
        if (x == 0)
            return 0;
        for (int i = 0; i < 32; i++)
            if (x[i])
                n = i;
        y = x << (30 - n);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        return (n << 16) | frac;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [13:0] bend_for(longint dev);
        longint lim;
        lim = ((brange == 0) ? 1 : longint'(brange)) * 65536;
        if (dev >= lim)
            return BEND_MAX;
        if (dev <= -lim)
            return BEND_MIN;
        return 14'((8192 * lim + dev * 8191) / lim);
    endfunction

    function automatic logic [6:0] velocity_for(logic [15:0] env);
        longint db;
        longint t;
        longint norm;
        longint unsigned s;
        longint unsigned v;
        norm = 0;
        if (env != 0)
        begin
            db = (log2_fix(env) - 983040) * 394566 / 65536;
            t = db + 3276800;
            norm = (t <= 0) ? 0 : t / 44;
            if (norm > 65536)
                norm = 65536;
        end
        s = int_sqrt(longint'(norm) << 16);
        v = (s * sens * 127) >> 24;
        if (v < 1)
            v = 1;
        if (v > 127)
            v = 127;
        return 7'(v);
    endfunction

    task automatic push_event(ev_kind_t k, logic [6:0] nn, logic [6:0] vel,
                              logic [13:0] bv, logic dr);
        midi_t m;
        m.event_kind = k;
        m.note_number = nn;
        m.velocity = vel;
        m.bend_value = bv;
        m.detector_reset = dr;
        m.last_event = 1'b0;
        step_ev = {step_ev, m};
    endtask

    task automatic end_note(logic dr);
        if (active)
        begin
            push_event(EV_NOTE_OFF, cur_note, 7'd0, BEND_CENTRE, dr);
            active = 1'b0;
            cur_note = '0;
            last_bend = BEND_CENTRE;
        end
    endtask

    task automatic clear_cand();
        cand_ok = 1'b0;
        cand_note = '0;
        stable_cnt = '0;
    endtask

    task automatic track_estimate(logic [22:0] freq, logic [15:0] env);
        longint pos;
        longint note;
        longint dev;
        logic [13:0] nb;
        logic [6:0] vel;
        if (freq == 0)
            return;
        pos = 4521984 + 12 * (log2_fix(freq) - 1099783);
        note = (pos >= 0) ? (pos + 32768) / 65536 : -((-pos + 32768) / 65536);
        if (active)
        begin
            dev = pos - (longint'(cur_note) << 16);
            if (dev < 0)
                dev = -dev;
            if (dev < (longint'(hyst) << 8))
                note = cur_note;
        end
        if (note < 0 || note > 127)
            return;
        if (!active || note != cur_note)
        begin
            if (cand_ok && note == cand_note)
            begin
                if (stable_cnt < 255)
                    stable_cnt++;
            end
            else
            begin
                cand_note = 7'(note);
                cand_ok = 1'b1;
                stable_cnt = 8'd1;
            end
            if (stable_cnt >= stable_req)
            begin
                end_note(1'b0);
                vel = velocity_for(env);
                cur_note = 7'(note);
                active = 1'b1;
                last_bend = BEND_CENTRE;
                if (bend_en)
                begin
                    nb = bend_for(pos - (note << 16));
                    push_event(EV_BEND, 7'd0, 7'd0, nb, 1'b0);
                    last_bend = nb;
                end
                push_event(EV_NOTE_ON, 7'(note), vel, BEND_CENTRE, 1'b0);
                clear_cand();
            end
        end
        else
        begin
            clear_cand();
            if (bend_en)
            begin
                nb = bend_for(pos - (longint'(cur_note) << 16));
                dev = longint'(nb) - longint'(last_bend);
                if (dev > BEND_STEP || dev < -BEND_STEP)
                begin
                    push_event(EV_BEND, 7'd0, 7'd0, nb, 1'b0);
                    last_bend = nb;
                end
            end
            else if (last_bend != BEND_CENTRE)
            begin
                push_event(EV_BEND, 7'd0, 7'd0, BEND_CENTRE, 1'b0);
                last_bend = BEND_CENTRE;
            end
        end
    endtask

    task automatic predict_request(sample_t s);
        step_ev.delete();
        if (s.req_type == REQ_FLUSH)
        begin
            end_note(1'b0);
            clear_cand();
            push_event(EV_BEND, 7'd0, 7'd0, BEND_CENTRE, 1'b0);
            last_bend = BEND_CENTRE;
        end
        else if (s.gate_open)
        begin
            gate_off_cnt = '0;
            if (s.estimate_valid)
                track_estimate(s.freq_q8, s.envelope_q15);
        end
        else if (active)
        begin
            if (gate_off_cnt < 16'hFFFF)
                gate_off_cnt++;
            if (gate_off_cnt > rel_samples)
            begin
                end_note(1'b1);
                clear_cand();
            end
        end
        if (step_ev.size() > 0)
            step_ev[step_ev.size() - 1].last_event = 1'b1;
        foreach (step_ev[i])
            event_q = {event_q, step_ev[i]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        midi_t e;
        if (!rst_n)
        begin
            sens = RST_SENSITIVITY;
            bend_en = RST_BEND_ENABLE;
            brange = RST_BEND_RANGE;
            hyst = RST_HYSTERESIS;
            stable_req = RST_STABLE_REQ;
            rel_samples = RST_RELEASE;
            cur_note = '0;
            active = 1'b0;
            clear_cand();
            last_bend = BEND_CENTRE;
            gate_off_cnt = '0;
            event_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_SENSITIVITY: sens = cfg_wdata[9:0];
                    CFG_BEND_ENABLE: bend_en = cfg_wdata[0];
                    CFG_BEND_RANGE:  brange = cfg_wdata[3:0];
                    CFG_HYSTERESIS:  hyst = cfg_wdata[11:0];
                    CFG_STABLE_REQ:  stable_req = cfg_wdata[7:0];
                    CFG_RELEASE:     rel_samples = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (midi_valid && !midi_stall)
            begin
                if (event_q.size() == 0)
                begin
                    $error("unexpected event %p", midi);
                    fail_count++;
                end
                else
                begin
                    e = event_q.pop_front();
                    if (midi.event_kind !== e.event_kind)
                    begin
                        $error("event_kind exp %0d got %0d", e.event_kind,
                               midi.event_kind);
                        fail_count++;
                    end
                    if (midi.note_number !== e.note_number)
                    begin
                        $error("note_number exp %0d got %0d", e.note_number,
                               midi.note_number);
                        fail_count++;
                    end
                    if (midi.velocity !== e.velocity)
                    begin
                        $error("velocity exp %0d got %0d", e.velocity,
                               midi.velocity);
                        fail_count++;
                    end
                    if (midi.bend_value !== e.bend_value)
                    begin
                        $error("bend_value exp %0d got %0d", e.bend_value,
                               midi.bend_value);
                        fail_count++;
                    end
                    if (midi.detector_reset !== e.detector_reset)
                    begin
                        $error("detector_reset exp %0d got %0d",
                               e.detector_reset, midi.detector_reset);
                        fail_count++;
                    end
                    if (midi.last_event !== e.last_event)
                    begin
                        $error("last_event exp %0d got %0d", e.last_event,
                               midi.last_event);
                        fail_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                predict_request(sample);
        end
    end

endmodule

FILE: verif/tb_mono_pitch_to_midi_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_pitch_to_midi_tracker_core
// Drives directed and random sample requests through several register
// settings with random gaps and output stalls; the checker scores events.
// ----------------------------------------------------------------------------
module tb_mono_pitch_to_midi_tracker_core;
    import mptk_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        midi_valid;
    logic        midi_stall;
    midi_t       midi;
    logic        cfg_wen;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          cycles;
    logic        stall_on;

    mono_pitch_to_midi_tracker_core dut (.*);

    mptk_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 200);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    endfunction

    // frequency in q8 Hz for a MIDI note plus a small detune
    function automatic logic [22:0] note_freq(int note, int cents);
        real f;
        f = 440.0 * (2.0 ** ((note - 69 + cents / 100.0) / 12.0)) * 256.0;
        if (f > 8388607.0)
            f = 8388607.0;
        return 23'($rtoi(f));
    endfunction

    // random output stall, quiet in some stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            midi_stall <= 1'b0;
        else if (stall_on)
            midi_stall <= ($urandom_range(0, 3) == 0);
        else
            midi_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    // hold valid into the next request when no gap follows
    task automatic send(sample_t s);
        int g;
        g = gap_len();
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_est(int note, int cents, logic [15:0] env);
        sample_t s;
        s.req_type = REQ_SAMPLE;
        s.gate_open = 1'b1;
        s.estimate_valid = 1'b1;
        s.freq_q8 = note_freq(note, cents);
        s.envelope_q15 = env;
        send(s);
    endtask

    task automatic send_raw(logic rq, logic g, logic e, logic [22:0] f,
                            logic [15:0] env);
        sample_t s;
        s.req_type = rq;
        s.gate_open = g;
        s.estimate_valid = e;
        s.freq_q8 = f;
        s.envelope_q15 = env;
        send(s);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int note;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 19);
            stall_on = (i % 40) < 30;
            if (k < 13)
            begin
                note = $urandom_range(20, 110);
                repeat ($urandom_range(1, 3))
                    send_est(note + $urandom_range(0, 1),
                             $urandom_range(0, 80) - 40, 16'($urandom_range(0, 32768)));
            end
            else if (k < 16)
                send_raw(REQ_SAMPLE, 1'b0, 1'($urandom), 23'($urandom), 16'($urandom));
            else if (k < 17)
                send_raw(REQ_FLUSH, 1'($urandom), 1'($urandom), 23'($urandom),
                         16'($urandom));
            else
                send_raw(REQ_SAMPLE, 1'b1, 1'($urandom), 23'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        cycles = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_wen = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases at reset settings
        send_raw(REQ_SAMPLE, 1'b1, 1'b1, 23'd0, 16'd1000);
        send_raw(REQ_SAMPLE, 1'b1, 1'b1, 23'h7FFFFF, 16'hFFFF);
        send_raw(REQ_SAMPLE, 1'b1, 1'b1, 23'd1, 16'd0);
        send_raw(REQ_SAMPLE, 1'b0, 1'b1, note_freq(60, 0), 16'd20000);
        send_est(60, 0, 16'd0);
        send_est(60, 10, 16'd0);
        send_est(60, 30, 16'd32768);
        send_est(60, -45, 16'd32768);
        send_est(72, 49, 16'hFFFF);
        send_est(72, 49, 16'd1);
        send_est(127, 0, 16'd100);
        send_est(127, 0, 16'd100);
        send_est(0, 0, 16'd5000);
        send_est(0, 0, 16'd5000);
        send_raw(REQ_FLUSH, 1'b0, 1'b0, 23'd0, 16'd0);
        send_raw(REQ_FLUSH, 1'b1, 1'b1, 23'h7FFFFF, 16'hFFFF);
        drain();

        // short release, bend off, zero range, zero stable count
        write_reg(CFG_RELEASE, 16'd0);
        write_reg(CFG_BEND_ENABLE, 16'd0);
        write_reg(CFG_BEND_RANGE, 16'd0);
        write_reg(CFG_STABLE_REQ, 16'd0);
        write_reg(CFG_SENSITIVITY, 16'd26);
        write_reg(CFG_HYSTERESIS, 16'd0);
        send_est(50, 20, 16'd30000);
        send_raw(REQ_SAMPLE, 1'b0, 1'b0, 23'd0, 16'd0);
        send_est(50, 20, 16'd30000);
        send_raw(REQ_SAMPLE, 1'b0, 1'b0, 23'd0, 16'd0);
        drain();
        random_phase(30);
        drain();

        write_reg(CFG_RELEASE, 16'd3);
        write_reg(CFG_BEND_ENABLE, 16'd1);
        write_reg(CFG_BEND_RANGE, 16'd12);
        write_reg(CFG_STABLE_REQ, 16'd1);
        write_reg(CFG_SENSITIVITY, 16'd512);
        write_reg(CFG_HYSTERESIS, 16'd3072);
        random_phase(30);
        drain();

        write_reg(CFG_RELEASE, 16'd65535);
        write_reg(CFG_BEND_RANGE, 16'd1);
        write_reg(CFG_STABLE_REQ, 16'd255);
        write_reg(CFG_HYSTERESIS, 16'd64);
        write_reg(CFG_SENSITIVITY, 16'hFFFF);
        repeat (20) send_est(64, 5, 16'd12000);
        drain();

        write_reg(CFG_RELEASE, 16'd5);
        write_reg(CFG_BEND_RANGE, 16'd15);
        write_reg(CFG_STABLE_REQ, 16'd2);
        write_reg(CFG_HYSTERESIS, 16'hFFFF);
        write_reg(CFG_SENSITIVITY, 16'd256);
        write_reg(CFG_BEND_ENABLE, 16'd1);
        random_phase(50);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
